### design/rdsod_pkg.sv
// Shared types and constants for the ratiometric divider with send-on-delta.
`default_nettype none
package rdsod_pkg;

  localparam int SAMPLE_W    = 11;
  localparam int SUM_W       = 15;
  localparam int COUNT_W     = 5;
  localparam int RES_W       = 20;
  localparam int READING_W   = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int FRAC_BITS   = 8;
  localparam int RATIO_SHIFT = 18;
  localparam int NEAR_LIMIT  = 20;
  localparam int NUM_W       = RES_W + SUM_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  localparam logic [COUNT_W-1:0] DEFAULT_COUNT = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(16);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_COUNT    = 3'd0,
    REG_UPPER_RESISTOR  = 3'd1,
    REG_LOWER_RESISTOR  = 3'd2,
    REG_DELTA_THRESHOLD = 3'd3,
    REG_DELTA_ENABLE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic group_end;
    logic skip;
    logic div_last;
    logic zero_result;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

### design/rdsod_in_if.sv
// Sample pair channel: valid, ready and one pair of converter samples.
`default_nettype none
interface rdsod_in_if;
  logic                          valid;
  logic                          ready;
  logic [rdsod_pkg::SAMPLE_W-1:0] ref_sample;
  logic [rdsod_pkg::SAMPLE_W-1:0] meas_sample;
  logic                          force_post;

  modport source (output valid, output ref_sample, output meas_sample, output force_post,
                  input ready);
  modport sink (input valid, input ref_sample, input meas_sample, input force_post,
                output ready);
endinterface
`default_nettype wire

### design/rdsod_out_if.sv
// Result channel: valid, ready, reading and post flag.
`default_nettype none
interface rdsod_out_if;
  logic                           valid;
  logic                           ready;
  logic [rdsod_pkg::READING_W-1:0] reading;
  logic                           post;

  modport source (output valid, output reading, output post, input ready);
  modport sink (input valid, input reading, input post, output ready);
endinterface
`default_nettype wire

### design/rdsod_datapath.sv
// Datapath: config registers, accumulators, multiplier, serial divider, output register.
`default_nettype none
module rdsod_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rdsod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rdsod_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [rdsod_pkg::SAMPLE_W-1:0]    ref_sample,
  input  wire logic [rdsod_pkg::SAMPLE_W-1:0]    meas_sample,
  input  wire logic                              force_post,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [rdsod_pkg::READING_W-1:0]        out_reading,
  output logic                                   out_post,
  input  wire rdsod_pkg::dp_cmd_t                cmd,
  output rdsod_pkg::dp_status_t                  status
);
  import rdsod_pkg::*;

  logic [COUNT_W-1:0]   sample_count;
  logic [RES_W-1:0]     upper_resistor;
  logic [RES_W-1:0]     lower_resistor;
  logic [READING_W-1:0] delta_threshold;
  logic                 delta_enable;

  logic [SUM_W-1:0]     ref_sum;
  logic [SUM_W-1:0]     meas_sum;
  logic [COUNT_W-1:0]   samples_taken;
  logic [READING_W-1:0] last_posted;
  logic                 last_posted_valid;

  logic [SUM_W-1:0]     r_hold;
  logic [SUM_W-1:0]     m_hold;
  logic                 force_hold;
  logic [NUM_W-1:0]     num;
  logic [SUM_W-1:0]     divisor;
  logic [SUM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [COUNT_W-1:0]   eff_n;
  logic [SUM_W-1:0]     ref_sum_next;
  logic [SUM_W-1:0]     meas_sum_next;
  logic [COUNT_W-1:0]   samples_taken_next;
  logic [SUM_W:0]       near_sum;
  logic                 clamp;
  logic                 both_set;
  logic                 upper_only;
  logic                 lower_only;
  logic [SUM_W-1:0]     diff_rm;
  logic [RES_W-1:0]     mul_a;
  logic [SUM_W-1:0]     mul_b;
  logic [RES_W+SUM_W-1:0] product;
  logic [NUM_W-1:0]     num_load;
  logic [SUM_W-1:0]     divisor_load;
  logic [SUM_W:0]       rem_sh;
  logic                 rem_ge;
  logic [READING_W-1:0] reading_sat;
  logic [READING_W-1:0] delta;
  logic                 post_calc;

  always_comb begin
    priority if (sample_count == '0) begin
      eff_n = COUNT_W'(1);
    end else if (sample_count > MAX_COUNT) begin
      eff_n = MAX_COUNT;
    end else begin
      eff_n = sample_count;
    end
  end

  assign ref_sum_next       = ref_sum + SUM_W'(ref_sample);
  assign meas_sum_next      = meas_sum + SUM_W'(meas_sample);
  assign samples_taken_next = samples_taken + COUNT_W'(1);
  assign near_sum           = {1'b0, meas_sum_next} + ((SUM_W+1)'(eff_n) * (SUM_W+1)'(NEAR_LIMIT));
  assign clamp              = near_sum >= {1'b0, ref_sum_next};

  assign both_set   = (upper_resistor != '0) && (lower_resistor != '0);
  assign upper_only = (upper_resistor != '0) && (lower_resistor == '0);
  assign lower_only = (upper_resistor == '0) && (lower_resistor != '0);
  assign diff_rm    = r_hold - m_hold;

  assign mul_a   = upper_only ? upper_resistor : lower_resistor;
  assign mul_b   = upper_only ? m_hold : diff_rm;
  assign product = (RES_W+SUM_W)'(mul_a) * (RES_W+SUM_W)'(mul_b);

  assign num_load = both_set ? NUM_W'({m_hold, {RATIO_SHIFT{1'b0}}})
                             : {product, {FRAC_BITS{1'b0}}};
  assign divisor_load = both_set ? r_hold : (upper_only ? diff_rm : m_hold);

  assign rem_sh = {rem, num[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};

  assign reading_sat = (num[NUM_W-1:READING_W] != '0) ? '1 : num[READING_W-1:0];
  assign delta       = (last_posted >= reading_sat) ? (last_posted - reading_sat)
                                                    : (reading_sat - last_posted);
  assign post_calc   = force_hold ||
                       (delta_enable && last_posted_valid && (delta > delta_threshold));

  assign status.group_end   = samples_taken_next >= eff_n;
  assign status.skip        = (r_hold == '0) || !(both_set || upper_only || lower_only) ||
                              (upper_only && (m_hold == r_hold)) ||
                              (lower_only && (m_hold == '0));
  assign status.div_last    = div_cnt == DIV_CNT_W'(NUM_W - 1);
  assign status.zero_result = !both_set && (num == '0);
  assign status.out_full    = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= DEFAULT_COUNT;
      upper_resistor    <= '0;
      lower_resistor    <= '0;
      delta_threshold   <= '0;
      delta_enable      <= 1'b0;
      ref_sum           <= '0;
      meas_sum          <= '0;
      samples_taken     <= '0;
      last_posted       <= '0;
      last_posted_valid <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SAMPLE_COUNT:    sample_count    <= cfg_wdata[COUNT_W-1:0];
          REG_UPPER_RESISTOR:  upper_resistor  <= cfg_wdata[RES_W-1:0];
          REG_LOWER_RESISTOR:  lower_resistor  <= cfg_wdata[RES_W-1:0];
          REG_DELTA_THRESHOLD: delta_threshold <= cfg_wdata[READING_W-1:0];
          REG_DELTA_ENABLE:    delta_enable    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (status.group_end) begin
          ref_sum       <= '0;
          meas_sum      <= '0;
          samples_taken <= '0;
        end else begin
          ref_sum       <= ref_sum_next;
          meas_sum      <= meas_sum_next;
          samples_taken <= samples_taken_next;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (delta_enable && post_calc) begin
          last_posted       <= reading_sat;
          last_posted_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.group_end) begin
      r_hold     <= ref_sum_next;
      m_hold     <= clamp ? ref_sum_next : meas_sum_next;
      force_hold <= force_post;
    end
    if (cmd.load_div) begin
      num     <= num_load;
      divisor <= divisor_load;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      num     <= {num[NUM_W-2:0], rem_ge};
      rem     <= rem_ge ? SUM_W'(rem_sh - {1'b0, divisor}) : rem_sh[SUM_W-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.emit) begin
      out_reading <= reading_sat;
      out_post    <= post_calc;
    end
  end

endmodule
`default_nettype wire

### design/rdsod_ctrl.sv
// Controller: sequences accumulate, multiply, divide and result transfer.
`default_nettype none
module rdsod_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output rdsod_pkg::dp_cmd_t          cmd,
  input  wire rdsod_pkg::dp_status_t  status
);
  import rdsod_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_POST
  } state_t;

  state_t state;

  assign in_ready     = state == S_IDLE;
  assign cmd.accept   = (state == S_IDLE) && in_valid;
  assign cmd.load_div = (state == S_MUL) && !status.skip;
  assign cmd.div_step = state == S_DIV;
  assign cmd.emit     = (state == S_POST) && !status.zero_result && !status.out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && status.group_end) state <= S_MUL;
        end
        S_MUL: begin
          state <= status.skip ? S_IDLE : S_DIV;
        end
        S_DIV: begin
          if (status.div_last) state <= S_POST;
        end
        S_POST: begin
          if (status.zero_result || !status.out_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/ratiometric_divider_with_send_on_delta_core.sv
// Top level of the ratiometric divider with send-on-delta posting.
// Usage:
//   samples: one transfer per converter sample pair (reference, measured,
//   force_post). Pairs are summed until sample_count pairs are in (zero acts
//   as one, more than 16 as 16); the pair that closes a group may produce one
//   transfer on results. A pair that does not close a group leaves ready high.
//   A pair that closes a group holds ready low for the computation: the
//   multiply state, the one-bit-per-cycle serial divider and the post state,
//   which forms the post flag and waits while the output register is full;
//   the next pair is taken once the controller is back in idle.
//   Groups with no defined result, or a zero result outside ratio mode, release
//   ready after the multiply state or after the divider, and produce no transfer.
//   results: an output register holds the reading; while the receiver stalls,
//   further pairs are still taken, and a later group result waits in the
//   controller until the register is free.
//   cfg: registers are written by index at any edge with cfg_wr_en high; the user must write
//   them only while the block is idle, which the block does not enforce. Reset (rst, synchronous)
//   clears the sums, the last posted value and out_valid, and restores register defaults.
`default_nettype none
module ratiometric_divider_with_send_on_delta_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rdsod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rdsod_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rdsod_in_if.sink                               samples,
  rdsod_out_if.source                            results
);
  import rdsod_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign samples.ready = in_ready;

  rdsod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  rdsod_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .ref_sample  (samples.ref_sample),
    .meas_sample (samples.meas_sample),
    .force_post  (samples.force_post),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .out_reading (results.reading),
    .out_post    (results.post),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
`default_nettype wire

### bench/rdsod_checker.sv
`timescale 1ns / 1ps
// Checker: follows register writes and sample transfers, predicts each reading, compares results.
module rdsod_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [rdsod_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rdsod_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rdsod_in_if                               samples,
  rdsod_out_if                              results,
  output int                                errors,
  output int                                pending,
  output int                                checked,
  output int                                posted
);
  import rdsod_pkg::*;

  typedef struct packed {
    logic [READING_W-1:0] reading;
    logic                 post;
  } reading_t;

  reading_t             expected_q[$];
  logic [COUNT_W-1:0]   group_size = DEFAULT_COUNT;
  logic [RES_W-1:0]     upper_res = '0;
  logic [RES_W-1:0]     lower_res = '0;
  logic [READING_W-1:0] threshold = '0;
  logic                 delta_on = 1'b0;
  logic [SUM_W-1:0]     ref_acc = '0;
  logic [SUM_W-1:0]     meas_acc = '0;
  logic [COUNT_W-1:0]   pairs_in = '0;
  logic [READING_W-1:0] last_post_value = '0;
  logic                 last_post_valid = 1'b0;
  int                   mismatch_count = 0;
  int                   checked_count = 0;
  int                   posted_count = 0;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned group_len();
    if (group_size == '0) return 1;
    if (group_size > MAX_COUNT) return MAX_COUNT;
    return group_size;
  endfunction

  // Add one pair to the sums; on a group end, work out the reading if there is one.
  function automatic bit accumulate_pair(input logic [SAMPLE_W-1:0] ref_s,
                                         input logic [SAMPLE_W-1:0] meas_s,
                                         input logic force_s, output reading_t res);
    int unsigned          n;
    logic [63:0]          r, m, v;
    logic [READING_W-1:0] value, spread;
    logic                 post;
    res = '0;
    n = group_len();
    ref_acc = ref_acc + SUM_W'(ref_s);
    meas_acc = meas_acc + SUM_W'(meas_s);
    pairs_in = pairs_in + 1'b1;
    if (pairs_in < n) return 1'b0;
    r = 64'(ref_acc);
    m = 64'(meas_acc);
    ref_acc = '0;
    meas_acc = '0;
    pairs_in = '0;
    if (m + 64'(NEAR_LIMIT) * 64'(n) >= r) m = r;
    if (r == 0) return 1'b0;
    if (upper_res != '0 && lower_res != '0) begin
      v = (m << RATIO_SHIFT) / r;
    end else if (upper_res != '0) begin
      if (m >= r) return 1'b0;
      v = ((64'(upper_res) * m) << FRAC_BITS) / (r - m);
      if (v == 0) return 1'b0;
    end else if (lower_res != '0) begin
      if (m == 0) return 1'b0;
      v = ((64'(lower_res) * (r - m)) << FRAC_BITS) / m;
      if (v == 0) return 1'b0;
    end else begin
      return 1'b0;
    end
    value = (v > 64'hFFFF_FFFF) ? '1 : v[READING_W-1:0];
    post = force_s;
    if (delta_on) begin
      if (!post && last_post_valid) begin
        spread = (last_post_value >= value) ? last_post_value - value : value - last_post_value;
        if (spread > threshold) post = 1'b1;
      end
      if (post) begin
        last_post_value = value;
        last_post_valid = 1'b1;
      end
    end
    res.reading = value;
    res.post = post;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    reading_t want, due;
    if (rst) begin
      expected_q.delete();
      group_size = DEFAULT_COUNT;
      upper_res = '0;
      lower_res = '0;
      threshold = '0;
      delta_on = 1'b0;
      ref_acc = '0;
      meas_acc = '0;
      pairs_in = '0;
      last_post_value = '0;
      last_post_valid = 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("reading %h with none expected", results.reading));
        end else begin
          want = expected_q.pop_front();
          checked_count++;
          if (results.reading !== want.reading)
            report_mismatch($sformatf("reading %h, expected %h", results.reading, want.reading));
          if (results.post !== want.post)
            report_mismatch($sformatf("post %b, expected %b for reading %h",
                                      results.post, want.post, want.reading));
          if (results.post === 1'b1) posted_count++;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SAMPLE_COUNT:    group_size = cfg_wdata[COUNT_W-1:0];
          REG_UPPER_RESISTOR:  upper_res = cfg_wdata[RES_W-1:0];
          REG_LOWER_RESISTOR:  lower_res = cfg_wdata[RES_W-1:0];
          REG_DELTA_THRESHOLD: threshold = cfg_wdata[READING_W-1:0];
          REG_DELTA_ENABLE:    delta_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        if (accumulate_pair(samples.ref_sample, samples.meas_sample, samples.force_post, due))
          expected_q.push_back(due);
      end
    end
    errors <= mismatch_count;
    pending <= expected_q.size();
    checked <= checked_count;
    posted <= posted_count;
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top: drives sample pairs and register writes, stalls the result side, gives the verdict.
module testbench;
  import rdsod_pkg::*;

  localparam int                     HOLD_CYCLES     = 400;
  localparam int                     DRAIN_CYCLES    = 60;
  localparam int                     RANDOM_PHASES   = 6;
  localparam int                     PAIRS_PER_PHASE = 80;
  localparam logic [CFG_INDEX_W-1:0] UNUSED_REG      = 3'd7;
  localparam logic [RES_W-1:0]       RES_MAX         = 20'd1000000;
  localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX      = 11'd2047;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     errors, pending, checked, posted;
  int                     sender_idle_pct = 0;
  int                     receiver_idle_pct = 0;
  int                     pairs_sent = 0;
  int                     settings_used = 0;
  bit                     hold_request = 1'b0;

  rdsod_in_if  samples_ch ();
  rdsod_out_if results_ch ();

  ratiometric_divider_with_send_on_delta_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  rdsod_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (samples_ch),
    .results   (results_ch),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .posted    (posted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb: timeout with %0d readings outstanding", pending);
    $display("tb: failure");
    $finish;
  end

  // Hold off for a long stretch on request, otherwise stall at random.
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      results_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  task automatic drive_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] cnt, input logic [31:0] up,
                              input logic [31:0] lo, input logic [31:0] thr,
                              input logic [31:0] en);
    drive_reg(REG_SAMPLE_COUNT, cnt);
    drive_reg(REG_UPPER_RESISTOR, up);
    drive_reg(REG_LOWER_RESISTOR, lo);
    drive_reg(REG_DELTA_THRESHOLD, thr);
    drive_reg(REG_DELTA_ENABLE, en);
    drive_reg(UNUSED_REG, $urandom);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic pause_for_results();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Drain results, then let a group with no result finish before touching registers.
  task automatic settle();
    pause_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] ref_s, input logic [SAMPLE_W-1:0] meas_s,
                           input logic force_s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid <= 1'b1;
    samples_ch.ref_sample <= ref_s;
    samples_ch.meas_sample <= meas_s;
    samples_ch.force_post <= force_s;
    do @(posedge clk); while (!samples_ch.ready);
    pairs_sent++;
  endtask

  task automatic random_pair();
    int r, m;
    r = $urandom_range(0, 2047);
    case ($urandom_range(0, 9))
      0: begin
        r = $urandom_range(0, 1) ? 2047 : 0;
        m = $urandom_range(0, 1) ? 2047 : 0;
      end
      1, 2, 3: m = r - 40 + int'($urandom_range(0, 60));
      default: m = $urandom_range(0, 2047);
    endcase
    if (m < 0) m = 0;
    if (m > 2047) m = 2047;
    send_pair(SAMPLE_W'(r), SAMPLE_W'(m), $urandom_range(0, 3) == 0);
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 1)) return value;
    return value | (junk << width);
  endfunction

  function automatic logic [31:0] pick_resistor();
    case ($urandom_range(0, 3))
      0: return 32'd1;
      1: return 32'(RES_MAX);
      2: return $urandom_range(1, 5000);
      default: return $urandom_range(1, 1000000);
    endcase
  endfunction

  task automatic random_setting(input int count_pick);
    logic [31:0] cnt, up, lo, thr;
    if (count_pick >= 0) cnt = count_pick;
    else if ($urandom_range(0, 9) < 7) cnt = $urandom_range(0, 3);
    else cnt = $urandom_range(4, 31);
    up = pick_resistor();
    lo = pick_resistor();
    case ($urandom_range(0, 7))
      0: begin
        up = '0;
        lo = '0;
      end
      1, 2: up = '0;
      3, 4: lo = '0;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: thr = '0;
      1: thr = '1;
      2: thr = $urandom_range(0, 4096);
      default: thr = $urandom;
    endcase
    program_regs(with_junk(cnt, COUNT_W), with_junk(up, RES_W), with_junk(lo, RES_W), thr,
                 with_junk($urandom_range(0, 1), 1));
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    samples_ch.valid = 1'b0;
    samples_ch.ref_sample = '0;
    samples_ch.meas_sample = '0;
    samples_ch.force_post = 1'b0;
    sender_idle_pct = 12;
    receiver_idle_pct = 82;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Upper resistor only, count of zero acting as one.
    program_regs(0, RES_MAX, 0, 0, 0);
    send_pair(SAMPLE_MAX, 0, 1'b0);
    send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_pair(0, 0, 1'b0);
    send_pair(SAMPLE_MAX, 2000, 1'b1);
    send_pair(100, 50, 1'b0);
    settle();
    // Lower resistor only: open sensor, near clamp down to zero, tiny reading.
    program_regs(1, 0, 1, 0, 0);
    send_pair(SAMPLE_MAX, 0, 1'b1);
    send_pair(2046, 2026, 1'b0);
    send_pair(SAMPLE_MAX, 2026, 1'b0);
    send_pair(1000, 1, 1'b0);
    settle();
    program_regs(1, 0, 0, 0, 0);
    send_pair(1500, 700, 1'b1);
    settle();
    // Ratio mode with send-on-delta at a zero threshold.
    program_regs(1, 1, RES_MAX, 0, 1);
    send_pair(SAMPLE_MAX, 0, 1'b0);
    send_pair(1, SAMPLE_MAX, 1'b1);
    send_pair(1, SAMPLE_MAX, 1'b0);
    send_pair(SAMPLE_MAX, 0, 1'b0);
    settle();
    // Lower the count in the middle of a group.
    program_regs(5, 1, 1, 32'hFFFF_FFFF, 1);
    send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_pair(1024, 1024, 1'b1);
    send_pair(0, 0, 1'b0);
    settle();
    program_regs(2, 1, 1, 32'hFFFF_FFFF, 1);
    send_pair(SAMPLE_MAX, 300, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          sender_idle_pct = 12;
          receiver_idle_pct = 82;
        end
        1: begin
          sender_idle_pct = 82;
          receiver_idle_pct = 12;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      settle();
      random_setting(phase == 0 ? 31 : (phase == 1 ? 16 : -1));
      for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
        if (i == PAIRS_PER_PHASE / 2 || $urandom_range(0, 49) == 0) pause_for_results();
        random_pair();
      end
    end

    // Long result stall while pairs keep coming, one group per pair.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    settle();
    program_regs(1, RES_MAX, 1, 0, 1);
    hold_request = 1'b1;
    repeat (40) random_pair();

    samples_ch.valid <= 1'b0;
    for (int i = 0; i < 20000 && pending != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d sample pairs over %0d register settings, idle and stall patterns, long hold",
             pairs_sent, settings_used);
    $display("tb: %0d readings compared, %0d with post set, %0d never arrived",
             checked, posted, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
